### hdl/mpwr_pkg.sv
`default_nettype none
package mpwr_pkg;

	localparam int MAX_WORDS = 64;

	typedef enum logic [1:0] {
		OP_EDGE = 2'd0,
		OP_TICK = 2'd1,
		OP_ARM  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// Edge classes carry the pulse-width decision; the other ops pass through.
	typedef enum logic [2:0] {
		CL_HALF1 = 3'd0,
		CL_HALF2 = 3'd1,
		CL_SYNC1 = 3'd2,
		CL_SYNC2 = 3'd3,
		CL_LOSE  = 3'd4,
		CL_TICK  = 3'd5,
		CL_ARM   = 3'd6,
		CL_NONE  = 3'd7
	} cls_t;

	typedef enum logic [2:0] {
		REG_HALF_BIT_MAX    = 3'd0,
		REG_SHORT_PULSE_MAX = 3'd1,
		REG_SYNC_SHORT_MAX  = 3'd2,
		REG_SYNC_LONG_MAX   = 3'd3,
		REG_IDLE_TIMEOUT    = 3'd4,
		REG_MAX_WORDS       = 3'd5
	} reg_t;

	typedef struct packed {
		logic [15:0] half_bit_max;
		logic [15:0] short_pulse_max;
		logic [15:0] sync_short_max;
		logic [15:0] sync_long_max;
		logic [15:0] idle_timeout;
		logic [6:0]  max_words;
	} cfg_t;

	typedef struct packed {
		logic valid;
		cls_t cls;
	} fq_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] word;
		logic        is_command;
		logic        accepted;
		logic [15:0] word_index;
	} result_t;

endpackage
`default_nettype wire

### hdl/mpwr_cfg.sv
`default_nettype none
module mpwr_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output mpwr_pkg::cfg_t     cfg
);
	import mpwr_pkg::*;

	cfg_t  cfg_q;
	reg_t  idx;
	logic  wr;

	assign idx    = reg_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_max    <= 16'd41;
			cfg_q.short_pulse_max <= 16'd68;
			cfg_q.sync_short_max  <= 16'd95;
			cfg_q.sync_long_max   <= 16'd122;
			cfg_q.idle_timeout    <= 16'd200;
			cfg_q.max_words       <= 7'd64;
		end else if (wr) begin
			case (idx)
				REG_HALF_BIT_MAX:    cfg_q.half_bit_max    <= pwdata[15:0];
				REG_SHORT_PULSE_MAX: cfg_q.short_pulse_max <= pwdata[15:0];
				REG_SYNC_SHORT_MAX:  cfg_q.sync_short_max  <= pwdata[15:0];
				REG_SYNC_LONG_MAX:   cfg_q.sync_long_max   <= pwdata[15:0];
				REG_IDLE_TIMEOUT:    cfg_q.idle_timeout    <= pwdata[15:0];
				REG_MAX_WORDS:       cfg_q.max_words       <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HALF_BIT_MAX:    prdata = {16'd0, cfg_q.half_bit_max};
			REG_SHORT_PULSE_MAX: prdata = {16'd0, cfg_q.short_pulse_max};
			REG_SYNC_SHORT_MAX:  prdata = {16'd0, cfg_q.sync_short_max};
			REG_SYNC_LONG_MAX:   prdata = {16'd0, cfg_q.sync_long_max};
			REG_IDLE_TIMEOUT:    prdata = {16'd0, cfg_q.idle_timeout};
			REG_MAX_WORDS:       prdata = {25'd0, cfg_q.max_words};
			default:             prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

### hdl/mpwr_front.sv
`default_nettype none
module mpwr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  mpwr_pkg::cfg_t cfg,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     operation,
	input  logic [15:0]    interval,
	output mpwr_pkg::fq_t  head,
	input  logic           take
);
	import mpwr_pkg::*;

	cls_t       cls;
	cls_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		case (op_t'(operation))
			OP_EDGE: begin
				if (interval <= cfg.short_pulse_max)
					cls = (interval <= cfg.half_bit_max) ? CL_HALF1 : CL_HALF2;
				else if (interval > cfg.sync_long_max)
					cls = CL_LOSE;
				else
					cls = (interval <= cfg.sync_short_max) ? CL_SYNC1 : CL_SYNC2;
			end
			OP_TICK: cls = CL_TICK;
			OP_ARM:  cls = CL_ARM;
			default: cls = CL_NONE;
		endcase
	end

	assign full       = (cnt_q == 2'd2);
	assign do_push    = push && !full;
	assign do_pop     = take && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.cls   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/mpwr_back.sv
`default_nettype none
module mpwr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mpwr_pkg::cfg_t    cfg,
	input  mpwr_pkg::fq_t     head,
	output logic              take,
	output logic              empty,
	input  logic              pop,
	output mpwr_pkg::result_t res
);
	import mpwr_pkg::*;

	logic        level_q, sync_q, par_q, cmd_q, recv_q;
	logic [1:0]  hu_q;
	logic [4:0]  bc_q;
	logic [15:0] sw_q, fw_q, idle_q;

	logic        level_n, sync_n, par_n, cmd_n, recv_n;
	logic [1:0]  hu_n;
	logic [4:0]  bc_n;
	logic [15:0] sw_n, fw_n, idle_n;
	logic        emit;
	result_t     rnew;

	result_t     rq_q [2];
	logic        rwr_q, rrd_q;
	logic [1:0]  rcnt_q;
	logic        do_pop;

	assign do_pop = pop && !empty;
	assign empty  = (rcnt_q == 2'd0);
	assign res    = rq_q[rrd_q];
	// Execute whenever the result queue has room, counting a slot freed this cycle.
	assign take   = head.valid && ((rcnt_q != 2'd2) || do_pop);

	always_comb begin
		logic [2:0] hu_sum;
		logic [6:0] lim;
		logic       acc;

		level_n = level_q; sync_n = sync_q; par_n = par_q; cmd_n = cmd_q;
		recv_n  = recv_q;  hu_n   = hu_q;   bc_n  = bc_q;  sw_n  = sw_q;
		fw_n    = fw_q;    idle_n = idle_q;
		emit    = 1'b0;
		rnew    = '0;
		hu_sum  = 3'd0;
		acc     = 1'b0;

		lim = (cfg.max_words > 7'(MAX_WORDS)) ? 7'(MAX_WORDS) : cfg.max_words;
		if (lim == 7'd0)
			lim = 7'd1;

		case (head.cls)
			CL_HALF1, CL_HALF2, CL_SYNC1, CL_SYNC2, CL_LOSE: begin
				level_n = !level_q;
				if (head.cls == CL_HALF1 || head.cls == CL_HALF2) begin
					hu_sum = {1'b0, hu_q} + ((head.cls == CL_HALF1) ? 3'd1 : 3'd2);
					hu_n   = (hu_sum > 3'd3) ? 2'd3 : hu_sum[1:0];
					if (hu_n == 2'd3)
						sync_n = 1'b0;
				end else if (head.cls == CL_LOSE) begin
					sync_n = 1'b0;
				end else begin
					idle_n = 16'd0;
					sync_n = 1'b1;
					sw_n   = 16'd0;
					par_n  = 1'b1;
					bc_n   = 5'd0;
					hu_n   = (head.cls == CL_SYNC1) ? 2'd1 : 2'd2;
					cmd_n  = !level_n;
				end
				if (sync_n && hu_n == 2'd2) begin
					idle_n = 16'd0;
					if (!bc_n[4]) begin
						sw_n  = {sw_n[14:0], level_n};
						par_n = par_n ^ level_n;
						bc_n  = bc_n + 5'd1;
						hu_n  = 2'd0;
					end else begin
						// parity bit: a mismatch means inverted polarity
						sync_n = 1'b0;
						if (level_n != par_n) begin
							level_n = !level_n;
							sw_n    = ~sw_n;
							cmd_n   = !cmd_n;
						end
						if (recv_q) begin
							if (fw_q == 16'd0) begin
								if (cmd_n) begin
									acc  = 1'b1;
									fw_n = 16'd1;
								end
							end else begin
								acc = (fw_q < {9'd0, lim});
								if (fw_q != 16'hFFFF)
									fw_n = fw_q + 16'd1;
							end
						end
						emit            = 1'b1;
						rnew.kind       = 1'b0;
						rnew.word       = sw_n;
						rnew.is_command = cmd_n;
						rnew.accepted   = acc;
						rnew.word_index = fw_q;
					end
				end
			end
			CL_TICK: begin
				if (idle_q != 16'hFFFF)
					idle_n = idle_q + 16'd1;
				if (recv_q && fw_q != 16'd0 && idle_n > cfg.idle_timeout) begin
					recv_n          = 1'b0;
					emit            = 1'b1;
					rnew.kind       = 1'b1;
					rnew.word_index = fw_q;
				end
			end
			CL_ARM: begin
				if (!recv_q) begin
					recv_n = 1'b1;
					fw_n   = 16'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0; sync_q <= 1'b0; par_q <= 1'b0; cmd_q <= 1'b0;
			recv_q  <= 1'b0; hu_q   <= 2'd0; bc_q  <= 5'd0; sw_q  <= 16'd0;
			fw_q    <= 16'd0; idle_q <= 16'd0;
		end else if (take) begin
			level_q <= level_n; sync_q <= sync_n; par_q <= par_n; cmd_q <= cmd_n;
			recv_q  <= recv_n;  hu_q   <= hu_n;   bc_q  <= bc_n;  sw_q  <= sw_n;
			fw_q    <= fw_n;    idle_q <= idle_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit)
			rq_q[rwr_q] <= rnew;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= 1'b0;
			rrd_q  <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			if (take && emit)
				rwr_q <= !rwr_q;
			if (do_pop)
				rrd_q <= !rrd_q;
			case ({take && emit, do_pop})
				2'b10:   rcnt_q <= rcnt_q + 2'd1;
				2'b01:   rcnt_q <= rcnt_q - 2'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/manchester_pulse_width_word_receiver.sv
// Manchester II word receiver driven by line-edge intervals.
// Input queue: present operation (edge, idle tick, arm frame) and interval,
// assert push; the item is taken at a clock edge with push high and full low.
// The front classifies each edge by its interval against the configured
// thresholds and parks each item in a two-entry queue; the back decodes
// bits, words and frame state and fills a two-entry result queue.
// Result queue: while empty is low the oldest result (kind, word, is_command,
// accepted, word_index) is on the ports; pop takes it.
// Each item is registered in the input queue, decoded by the back as it
// is taken from there, and its result is registered in the result queue.
// Throughput: one item per cycle sustained, set by the decode step in
// the back, while the result queue has room or is popped. If pop is held
// low, the result queue fills, the back stops, then the input queue fills
// and full rises. Items that produce no result (most edges, ticks, arms)
// still pass the back like any other and also wait for result queue room.
// Thresholds are written over the APB port at byte address 4*index; write
// them only while the block is idle.
// Reset (arst_n low) empties both queues, clears the decoder and frame
// state and restores the register defaults.
`default_nettype none
module manchester_pulse_width_word_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [15:0] interval,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [15:0] word,
	output logic        is_command,
	output logic        accepted,
	output logic [15:0] word_index,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mpwr_pkg::*;

	cfg_t    cfg;
	fq_t     head;
	logic    take;
	result_t res;

	mpwr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mpwr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.operation (operation),
		.interval  (interval),
		.head      (head),
		.take      (take)
	);

	mpwr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	assign kind       = res.kind;
	assign word       = res.word;
	assign is_command = res.is_command;
	assign accepted   = res.accepted;
	assign word_index = res.word_index;

endmodule
`default_nettype wire

### hdl/mpwr_checker.sv
`default_nettype none
module mpwr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [15:0] word,
	input logic        is_command,
	input logic        accepted,
	input logic [15:0] word_index
);
	import mpwr_pkg::*;

	// nothing can come out right after reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty after reset");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind) |-> (word == 16'd0 && !is_command && !accepted))
		else $error("frame-end result carries word fields");

	a_first_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind && accepted && word_index == 16'd0) |-> is_command)
		else $error("frame opened by a non-command word");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind && accepted) |-> (word_index < 16'(MAX_WORDS)))
		else $error("word stored beyond the frame limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(word) && $stable(word_index)))
		else $error("stalled result changed");

endmodule

bind manchester_pulse_width_word_receiver mpwr_checker u_mpwr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.kind       (kind),
	.word       (word),
	.is_command (is_command),
	.accepted   (accepted),
	.word_index (word_index)
);
`default_nettype wire
